FILE: sv/tmf_pkg.sv
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 12;

    localparam int STATUS_W = 16;
    localparam int RAW_W    = 13;
    localparam int POS_W    = 12;
    localparam int THR_W    = 12;
    localparam int RING_D   = 4;
    localparam int SLOT_W   = $clog2(RING_D);
    localparam int FILL_W   = 3;

    localparam int PEN_A_BIT  = 12;
    localparam int PEN_B_BIT  = 13;
    localparam int SAMPLE_BIT = 14;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(80);
    localparam logic [FILL_W-1:0] FILL_FULL       = FILL_W'(RING_D + 1);

    typedef enum logic [1:0] {
        PEN_IDLE     = 2'd0,
        PEN_ARMED    = 2'd1,
        PEN_SAMPLING = 2'd2
    } pen_phase_t;

endpackage

FILE: sv/touch_median_filter_pen_fsm.sv
`timescale 1ns / 1ps

// Touch interrupt filter: each request carries the status word and the raw X/Y
// conversions and yields exactly one result (release flag, touch flag with
// filtered X/Y, and an ack mask equal to the status word). A request can be
// taken every clock cycle unless the output stalls; each request passes through
// one input register and then one result register, and the result register lets
// the next request in while a result is still stalled. Pen events clear the
// four-deep sample history; a touch is reported from the fifth sample on, as the
// rounded-up mean of the two middle sorted samples per axis, when both middle
// spreads are at most stable_threshold (reset value 80). Write stable_threshold
// only while no request is in flight.
module touch_median_filter_pen_fsm #(
    parameter int SAMPLE_WIDTH = tmf_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_write,
    input  logic [tmf_pkg::THR_W-1:0]    cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tmf_pkg::STATUS_W-1:0] status_bits,
    input  logic [tmf_pkg::RAW_W-1:0]    raw_x,
    input  logic [tmf_pkg::RAW_W-1:0]    raw_y,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         release_event,
    output logic                         touch_event,
    output logic [tmf_pkg::POS_W-1:0]    x_position,
    output logic [tmf_pkg::POS_W-1:0]    y_position,
    output logic [tmf_pkg::STATUS_W-1:0] ack_mask
);

    localparam int WIDE_W = (SAMPLE_WIDTH > tmf_pkg::THR_W) ? SAMPLE_WIDTH : tmf_pkg::THR_W;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] mean;
        logic [SAMPLE_WIDTH-1:0] spread;
    } mid_t;

    function automatic mid_t middle_of_four(
        input logic [SAMPLE_WIDTH-1:0] v0,
        input logic [SAMPLE_WIDTH-1:0] v1,
        input logic [SAMPLE_WIDTH-1:0] v2,
        input logic [SAMPLE_WIDTH-1:0] v3
    );
        logic [SAMPLE_WIDTH-1:0] a;
        logic [SAMPLE_WIDTH-1:0] b;
        logic [SAMPLE_WIDTH-1:0] c;
        logic [SAMPLE_WIDTH-1:0] d;
        logic [SAMPLE_WIDTH-1:0] t;
        logic [SAMPLE_WIDTH:0]   sum;
        mid_t                    r;
        a = v0;
        b = v1;
        c = v2;
        d = v3;
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (c > d)
        begin
            t = c; c = d; d = t;
        end
        if (a > c)
        begin
            t = a; a = c; c = t;
        end
        if (b > d)
        begin
            t = b; b = d; d = t;
        end
        if (b > c)
        begin
            t = b; b = c; c = t;
        end
        sum      = {1'b0, b} + {1'b0, c} + (SAMPLE_WIDTH + 1)'(1);
        r.mean   = sum[SAMPLE_WIDTH:1];
        r.spread = c - b;
        return r;
    endfunction

    // configuration
    logic [tmf_pkg::THR_W-1:0] threshold_reg;

    // input register
    logic                         in_valid_reg;
    logic [tmf_pkg::STATUS_W-1:0] status_reg;
    logic [tmf_pkg::RAW_W-1:0]    raw_x_reg;
    logic [tmf_pkg::RAW_W-1:0]    raw_y_reg;

    // filter and pen state
    logic [SAMPLE_WIDTH-1:0]    x_ring_reg [tmf_pkg::RING_D];
    logic [SAMPLE_WIDTH-1:0]    y_ring_reg [tmf_pkg::RING_D];
    logic [tmf_pkg::SLOT_W-1:0] slot_reg;
    logic [tmf_pkg::SLOT_W-1:0] slot_next;
    logic [tmf_pkg::FILL_W-1:0] fill_reg;
    logic [tmf_pkg::FILL_W-1:0] fill_next;
    tmf_pkg::pen_phase_t        phase_reg;
    tmf_pkg::pen_phase_t        phase_next;

    // result register
    logic                         out_valid_reg;
    logic                         release_reg;
    logic                         touch_reg;
    logic [tmf_pkg::POS_W-1:0]    x_pos_reg;
    logic [tmf_pkg::POS_W-1:0]    y_pos_reg;
    logic [tmf_pkg::STATUS_W-1:0] ack_reg;

    logic                         advance;
    logic                         pen_a;
    logic                         pen_b;
    logic                         take_sample;
    logic                         clear_hist;
    logic                         release_now;
    logic [tmf_pkg::SLOT_W-1:0]   slot_base;
    logic [tmf_pkg::FILL_W-1:0]   fill_base;
    logic [SAMPLE_WIDTH-1:0]      x_sample;
    logic [SAMPLE_WIDTH-1:0]      y_sample;
    logic [SAMPLE_WIDTH-1:0]      x_view [tmf_pkg::RING_D];
    logic [SAMPLE_WIDTH-1:0]      y_view [tmf_pkg::RING_D];
    mid_t                         x_mid;
    mid_t                         y_mid;
    logic                         stable;
    logic                         touch_now;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    assign pen_a       = status_reg[tmf_pkg::PEN_A_BIT];
    assign pen_b       = status_reg[tmf_pkg::PEN_B_BIT];
    assign take_sample = status_reg[tmf_pkg::SAMPLE_BIT];
    assign clear_hist  = pen_a || pen_b;

    // pen phase: next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            tmf_pkg::PEN_IDLE:
            begin
                if (pen_a && pen_b)
                    phase_next = tmf_pkg::PEN_IDLE;
                else if (pen_a)
                    phase_next = tmf_pkg::PEN_ARMED;
                else if (pen_b)
                    phase_next = tmf_pkg::PEN_IDLE;
            end
            default:
            begin
                if (pen_a && pen_b)
                    phase_next = tmf_pkg::PEN_ARMED;
                else if (pen_a || pen_b)
                    phase_next = tmf_pkg::PEN_IDLE;
            end
        endcase
        if (take_sample)
            phase_next = tmf_pkg::PEN_SAMPLING;
    end

    // pen phase: outputs
    always_comb
    begin
        case (phase_reg)
            tmf_pkg::PEN_IDLE: release_now = pen_b;
            default:           release_now = pen_a || pen_b;
        endcase
    end

    // sample history
    assign slot_base = clear_hist ? '0 : slot_reg;
    assign fill_base = clear_hist ? '0 : fill_reg;
    assign x_sample  = SAMPLE_WIDTH'(raw_x_reg[tmf_pkg::RAW_W-1:1]);
    assign y_sample  = SAMPLE_WIDTH'(raw_y_reg[tmf_pkg::RAW_W-1:1]);

    always_comb
    begin
        slot_next = slot_base;
        fill_next = fill_base;
        if (take_sample)
        begin
            slot_next = slot_base + tmf_pkg::SLOT_W'(1);
            if (fill_base < tmf_pkg::FILL_FULL)
                fill_next = fill_base + tmf_pkg::FILL_W'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < tmf_pkg::RING_D; i++)
        begin
            if (take_sample && (slot_base == tmf_pkg::SLOT_W'(i)))
            begin
                x_view[i] = x_sample;
                y_view[i] = y_sample;
            end
            else
            begin
                x_view[i] = x_ring_reg[i];
                y_view[i] = y_ring_reg[i];
            end
        end
    end

    assign x_mid = middle_of_four(x_view[0], x_view[1], x_view[2], x_view[3]);
    assign y_mid = middle_of_four(y_view[0], y_view[1], y_view[2], y_view[3]);

    assign stable = (WIDE_W'(x_mid.spread) <= WIDE_W'(threshold_reg))
                 && (WIDE_W'(y_mid.spread) <= WIDE_W'(threshold_reg));
    assign touch_now = take_sample && (fill_next == tmf_pkg::FILL_FULL) && stable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tmf_pkg::THRESHOLD_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            phase_reg     <= tmf_pkg::PEN_IDLE;
        end
        else
        begin
            if (cfg_write)
                threshold_reg <= cfg_data;
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                slot_reg  <= slot_next;
                fill_reg  <= fill_next;
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            status_reg <= status_bits;
            raw_x_reg  <= raw_x;
            raw_y_reg  <= raw_y;
        end
        if (advance)
        begin
            if (take_sample)
            begin
                x_ring_reg[slot_base] <= x_sample;
                y_ring_reg[slot_base] <= y_sample;
            end
            release_reg <= release_now;
            touch_reg   <= touch_now;
            x_pos_reg   <= touch_now ? tmf_pkg::POS_W'(x_mid.mean) : '0;
            y_pos_reg   <= touch_now ? tmf_pkg::POS_W'(y_mid.mean) : '0;
            ack_reg     <= status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign release_event = release_reg;
    assign touch_event   = touch_reg;
    assign x_position    = x_pos_reg;
    assign y_position    = y_pos_reg;
    assign ack_mask      = ack_reg;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tmf_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEFAULT;

    localparam logic [STATUS_W-1:0] CAUSE_PEN_A  = STATUS_W'(1) << PEN_A_BIT;
    localparam logic [STATUS_W-1:0] CAUSE_PEN_B  = STATUS_W'(1) << PEN_B_BIT;
    localparam logic [STATUS_W-1:0] CAUSE_SAMPLE = STATUS_W'(1) << SAMPLE_BIT;

    typedef struct packed {
        logic             rel;
        logic             touch;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [STATUS_W-1:0] ack;
    } touch_report_t;

    typedef struct packed {
        logic [SW-1:0] spread;
        logic [SW-1:0] mean;
    } pair_stat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [THR_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [STATUS_W-1:0] status_bits = '0;
    logic [RAW_W-1:0]    raw_x = '0;
    logic [RAW_W-1:0]    raw_y = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                release_event;
    logic                touch_event;
    logic [POS_W-1:0]    x_position;
    logic [POS_W-1:0]    y_position;
    logic [STATUS_W-1:0] ack_mask;

    touch_median_filter_pen_fsm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .status_bits   (status_bits),
        .raw_x         (raw_x),
        .raw_y         (raw_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .release_event (release_event),
        .touch_event   (touch_event),
        .x_position    (x_position),
        .y_position    (y_position),
        .ack_mask      (ack_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter state mirror
    logic [THR_W-1:0]  stable_thresh = THRESHOLD_RESET;
    logic [SW-1:0]     x_hist [RING_D];
    logic [SW-1:0]     y_hist [RING_D];
    logic [SLOT_W-1:0] hist_slot = '0;
    logic [FILL_W-1:0] hist_fill = '0;
    pen_phase_t        pen_state = PEN_IDLE;

    touch_report_t pending_reports [$];
    int items_sent = 0;
    int mismatches = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    function automatic pair_stat_t middle_pair(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                               input logic [SW-1:0] c, input logic [SW-1:0] d);
        logic [SW-1:0] t;
        logic [SW:0]   sum;
        pair_stat_t    p;
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (c > d)
        begin
            t = c; c = d; d = t;
        end
        if (a > c)
        begin
            t = a; a = c; c = t;
        end
        if (b > d)
        begin
            t = b; b = d; d = t;
        end
        if (b > c)
        begin
            t = b; b = c; c = t;
        end
        p.spread = c - b;
        sum = {1'b0, b} + {1'b0, c} + 1'b1;
        p.mean = sum[SW:1];
        return p;
    endfunction

    function automatic touch_report_t predict_interrupt(input logic [STATUS_W-1:0] cause,
                                                        input logic [RAW_W-1:0] rx,
                                                        input logic [RAW_W-1:0] ry);
        touch_report_t       r;
        logic [STATUS_W-1:0] open_bits;
        pair_stat_t          sx;
        pair_stat_t          sy;
        r = '0;
        open_bits = cause;
        if (open_bits[PEN_A_BIT] && open_bits[PEN_B_BIT])
        begin
            hist_fill = '0;
            hist_slot = '0;
            if (pen_state == PEN_IDLE)
            begin
                open_bits[PEN_A_BIT] = 1'b0;
                pen_state = PEN_ARMED;
            end
            else
            begin
                open_bits[PEN_B_BIT] = 1'b0;
                r.rel = 1'b1;
                pen_state = PEN_IDLE;
            end
        end
        if (open_bits[PEN_A_BIT])
        begin
            hist_fill = '0;
            hist_slot = '0;
            if (pen_state == PEN_IDLE)
                pen_state = PEN_ARMED;
            else
            begin
                r.rel = 1'b1;
                pen_state = PEN_IDLE;
            end
        end
        if (open_bits[PEN_B_BIT])
        begin
            hist_fill = '0;
            hist_slot = '0;
            r.rel = 1'b1;
            pen_state = PEN_IDLE;
        end
        if (open_bits[SAMPLE_BIT])
        begin
            x_hist[hist_slot] = SW'(rx >> 1);
            y_hist[hist_slot] = SW'(ry >> 1);
            hist_slot = hist_slot + 1'b1;
            if (hist_fill < FILL_FULL)
                hist_fill = hist_fill + 1'b1;
            if (hist_fill >= FILL_FULL)
            begin
                sx = middle_pair(x_hist[0], x_hist[1], x_hist[2], x_hist[3]);
                sy = middle_pair(y_hist[0], y_hist[1], y_hist[2], y_hist[3]);
                if (sx.spread <= stable_thresh && sy.spread <= stable_thresh)
                begin
                    r.touch = 1'b1;
                    r.x = POS_W'(sx.mean);
                    r.y = POS_W'(sy.mean);
                end
            end
            pen_state = PEN_SAMPLING;
        end
        r.ack = cause;
        return r;
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    always @(posedge clk)
    begin : check_reports
        touch_report_t got;
        touch_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{release_event, touch_event, x_position, y_position, ack_mask};
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: rel=%0b touch=%0b x=%0d y=%0d ack=%h",
                             got.rel, got.touch, got.x, got.y, got.ack);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.rel !== want.rel || got.touch !== want.touch || got.x !== want.x ||
                    got.y !== want.y || got.ack !== want.ack)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("report mismatch at %0t: exp rel=%0b touch=%0b x=%0d y=%0d ack=%h",
                                 $realtime, want.rel, want.touch, want.x, want.y, want.ack);
                        $display("    got rel=%0b touch=%0b x=%0d y=%0d ack=%h",
                                 got.rel, got.touch, got.x, got.y, got.ack);
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [STATUS_W-1:0] cause, input logic [RAW_W-1:0] rx,
                                input logic [RAW_W-1:0] ry);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        status_bits <= cause;
        raw_x       <= rx;
        raw_y       <= ry;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reports.push_back(predict_interrupt(cause, rx, ry));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        stable_thresh = value;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        in_idle_pct   = sender_pct;
        out_stall_pct = receiver_pct;
    endtask

    // unrelated cause bits, pen and sample bits kept clear
    function automatic logic [STATUS_W-1:0] extra_bits();
        logic [STATUS_W-1:0] b;
        b = '0;
        if ($urandom_range(0, 3) == 0)
        begin
            b = STATUS_W'($urandom_range(0, 65535));
            b[PEN_A_BIT]  = 1'b0;
            b[PEN_B_BIT]  = 1'b0;
            b[SAMPLE_BIT] = 1'b0;
        end
        return b;
    endfunction

    function automatic logic [RAW_W-1:0] near(input int center, input int jitter);
        int v;
        v = center + int'($urandom_range(0, 2 * jitter)) - jitter;
        if (v < 0)
            v = 0;
        if (v > 8191)
            v = 8191;
        return RAW_W'(v);
    endfunction

    // pen down, a run of samples around one point, pen up
    task automatic run_stroke(input int cx, input int cy, input int jitter, input int count,
                              input bit broken);
        logic [STATUS_W-1:0] cause;
        int                  break_at;
        logic [STATUS_W-1:0] pen_bits;
        break_at = broken ? int'($urandom_range(0, count - 1)) : -1;
        pen_bits = '0;
        pen_bits[PEN_A_BIT] = 1'b1;
        send_request(pen_bits | extra_bits(), RAW_W'($urandom_range(0, 8191)),
                     RAW_W'($urandom_range(0, 8191)));
        for (int i = 0; i < count; i++)
        begin
            cause = extra_bits();
            cause[SAMPLE_BIT] = 1'b1;
            if (i == break_at)
            begin
                cause[PEN_A_BIT] = 1'($urandom_range(0, 1));
                cause[PEN_B_BIT] = 1'($urandom_range(0, 1));
            end
            send_request(cause, near(cx, jitter), near(cy, jitter));
        end
        cause = extra_bits();
        case ($urandom_range(0, 3))
            0: cause[PEN_A_BIT] = 1'b1;
            1:
            begin
                cause[PEN_A_BIT] = 1'b1;
                cause[PEN_B_BIT] = 1'b1;
            end
            default: cause[PEN_B_BIT] = 1'b1;
        endcase
        send_request(cause, RAW_W'($urandom_range(0, 8191)), RAW_W'($urandom_range(0, 8191)));
    endtask

    task automatic test_directed();
        send_request('0, 13'd0, 13'd0);
        send_request(CAUSE_PEN_A, 13'd0, 13'd0);
        send_request(CAUSE_PEN_A, 13'd5, 13'd5);
        send_request(CAUSE_PEN_A | CAUSE_PEN_B, 13'd0, 13'd0);
        send_request(CAUSE_PEN_A, 13'd0, 13'd0);
        send_request(CAUSE_PEN_A | CAUSE_PEN_B, 13'd0, 13'd0);
        // spread of exactly the reset threshold, y pinned at full scale
        send_request(CAUSE_SAMPLE, 13'd2000, 13'd8191);
        send_request(CAUSE_SAMPLE, 13'd2000, 13'd8191);
        send_request(CAUSE_SAMPLE, 13'd2160, 13'd8191);
        send_request(CAUSE_SAMPLE, 13'd2161, 13'd8190);
        send_request(CAUSE_SAMPLE, 13'd2001, 13'd8191);
        send_request(CAUSE_SAMPLE, 13'd2162, 13'd8190);
        send_request(CAUSE_SAMPLE, 13'd0, 13'd0);
        send_request(CAUSE_SAMPLE, 13'd8191, 13'd1);
        send_request(CAUSE_PEN_A | CAUSE_SAMPLE, 13'd4097, 13'd4096);
        send_request(CAUSE_PEN_B, 13'd0, 13'd0);
        send_request(CAUSE_PEN_B, 13'd0, 13'd0);
        send_request(CAUSE_PEN_A | CAUSE_PEN_B | CAUSE_SAMPLE, 13'd8191, 13'd0);
        send_request(16'hFFFF, 13'd8191, 13'd8191);
        send_request(16'h8FFF, 13'h0AAA, 13'h1555);
        send_request(16'h0FFF, 13'd0, 13'd0);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(12'd0);
        run_stroke(4000, 6000, 1, 8, 1'b0);
        run_stroke(8191, 0, 0, 7, 1'b0);
        write_threshold(12'd4095);
        run_stroke(4096, 4096, 4096, 9, 1'b0);
        run_stroke(0, 8191, 0, 6, 1'b0);
        write_threshold(THRESHOLD_RESET);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int jitter;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_threshold(THR_W'($urandom_range(0, 4095)));
                else
                    write_threshold(THR_W'($urandom_range(0, 200)));
            end
            else if ($urandom_range(0, 99) < 15)
                send_request(STATUS_W'($urandom_range(0, 65535)),
                             RAW_W'($urandom_range(0, 8191)), RAW_W'($urandom_range(0, 8191)));
            else
            begin
                case ($urandom_range(0, 3))
                    0: jitter = $urandom_range(0, 3);
                    1: jitter = $urandom_range(0, 80);
                    2: jitter = $urandom_range(0, 400);
                    default: jitter = 8191;
                endcase
                run_stroke($urandom_range(0, 8191), $urandom_range(0, 8191), jitter,
                           $urandom_range(1, 12), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(14, 83);
        test_directed();
        test_threshold_extremes();
        test_random_traffic(650);
        set_idling(83, 14);
        test_random_traffic(650);
        set_idling(0, 0);
        test_random_traffic(560);
        wait_drained();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tmf_pkg.sv
sv/touch_median_filter_pen_fsm.sv
dv/tb.sv
